// File: hdl/dwm_pkg.sv
// shared types and constants for the dfa word matcher
// no dependencies; imported by the matcher modules and the checker
package dwm_pkg;

	localparam int STATE_COUNT_DEF = 64;
	localparam int SYMBOL_BITS_DEF = 8;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_FLAG = 2'd1,
		OP_FEED = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		V_RUN     = 2'd0,
		V_ACCEPT  = 2'd1,
		V_NOTRANS = 2'd2,
		V_REJECT  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [5:0] current_state;
		verdict_t   verdict;
		logic       word_end;
	} result_t;

	typedef struct packed {
		logic empty;
		logic full;
	} buf_status_t;

endpackage

// File: hdl/dfa_word_matcher.sv
// table-driven dfa word matcher: top level with the feed pipeline
// depends on dwm_pkg, dwm_ram, dwm_clear and dwm_outbuf
//
// Each item is a table load, an accepting-flag write or one symbol of a word. Loads and
// flag writes are taken one per cycle once the clearing pass is done. A feed is held off
// while the previous feed is in the registered transition table read, since the next
// symbol's table address needs the state that comes back from that read. A result goes
// through the table read and result registers and a two-entry output buffer, so the
// block keeps taking items while a result waits, feeds only while the buffer has room.
// After reset a clearing pass writes every table entry and accepting flag, during which
// item_stall stays high.
module dfa_word_matcher #(
	parameter int STATE_COUNT = dwm_pkg::STATE_COUNT_DEF,
	parameter int SYMBOL_BITS = dwm_pkg::SYMBOL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] operation,
	input  logic [5:0] state_index,
	input  logic [7:0] symbol,
	input  logic [5:0] target_state,
	input  logic       flag_value,
	input  logic       last_symbol,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [5:0] current_state,
	output logic [1:0] verdict,
	output logic       word_end
);
	import dwm_pkg::*;

	localparam int SW = $clog2(STATE_COUNT);
	localparam int AW = SW + SYMBOL_BITS;
	localparam int TABLE_DEPTH = STATE_COUNT << SYMBOL_BITS;

	logic              item_acc;
	logic              clr_busy;
	logic [AW-1:0]     clr_addr;
	logic              clr_acc_hit;

	logic              t_we;
	logic [AW-1:0]     t_waddr;
	logic [SW:0]       t_wdata;
	logic [AW-1:0]     t_raddr;
	logic [SW:0]       t_rdata;

	logic              a_we;
	logic [SW-1:0]     a_waddr;
	logic              a_wdata;
	logic              a_rdata;

	logic [SW-1:0]     pstate_q;
	logic              dead_q;
	logic              feed_s1_q;
	logic              last_s1_q;
	logic              feed_s2_q;
	logic              last_s2_q;
	logic              dead_s2_q;
	logic [SW-1:0]     state_s2_q;

	logic [SW-1:0]     nstate;
	logic              ndead;
	logic              src_ok;
	logic              dst_ok;

	result_t           res;
	result_t           head;
	buf_status_t       bs;

	dwm_clear #(.DEPTH(TABLE_DEPTH)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// feeds wait for the table read of the previous one and for buffer room
	always_comb begin
		item_stall = clr_busy;
		if (op_t'(operation) == OP_FEED &&
		    (feed_s1_q || (feed_s2_q ? !bs.empty : bs.full))) begin
			item_stall = 1'b1;
		end
	end

	assign item_acc = item_valid && !item_stall;
	assign src_ok   = 32'(state_index) < STATE_COUNT;
	assign dst_ok   = 32'(target_state) < STATE_COUNT;

	// transition table: {valid, target}
	assign t_we    = clr_busy ||
	                 (item_acc && op_t'(operation) == OP_LOAD && src_ok && dst_ok);
	assign t_waddr = clr_busy ? clr_addr : {SW'(state_index), symbol[SYMBOL_BITS-1:0]};
	assign t_wdata = clr_busy ? '0 : {flag_value, SW'(target_state)};
	assign t_raddr = {pstate_q, symbol[SYMBOL_BITS-1:0]};

	dwm_ram #(.WIDTH(SW + 1), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// step the automaton once the table entry is back
	always_comb begin
		nstate = pstate_q;
		ndead  = 1'b1;
		if (dead_q) begin
			ndead = 1'b1;
		end else if (t_rdata[SW]) begin
			nstate = t_rdata[SW-1:0];
			ndead  = 1'b0;
		end
	end

	assign clr_acc_hit = 32'(clr_addr) < STATE_COUNT;
	assign a_we    = (clr_busy && clr_acc_hit) ||
	                 (item_acc && op_t'(operation) == OP_FLAG && src_ok);
	assign a_waddr = clr_busy ? clr_addr[SW-1:0] : SW'(state_index);
	assign a_wdata = clr_busy ? 1'b0 : flag_value;

	// read-old on a same-cycle flag write keeps transaction order
	dwm_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_accept (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (nstate),
		.rdata (a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate_q  <= '0;
			dead_q    <= 1'b0;
			feed_s1_q <= 1'b0;
			feed_s2_q <= 1'b0;
		end else begin
			feed_s1_q <= item_acc && op_t'(operation) == OP_FEED;
			feed_s2_q <= feed_s1_q;
			if (feed_s1_q) begin
				pstate_q <= last_s1_q ? '0 : nstate;
				dead_q   <= last_s1_q ? 1'b0 : ndead;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1_q  <= last_symbol;
		last_s2_q  <= last_s1_q;
		dead_s2_q  <= ndead;
		state_s2_q <= nstate;
	end

	always_comb begin
		res.current_state = 6'(state_s2_q);
		res.word_end      = last_s2_q;
		if (!last_s2_q)     res.verdict = V_RUN;
		else if (dead_s2_q) res.verdict = V_NOTRANS;
		else if (a_rdata)   res.verdict = V_ACCEPT;
		else                res.verdict = V_REJECT;
	end

	dwm_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (feed_s2_q),
		.push_data    (res),
		.status       (bs),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign current_state = head.current_state;
	assign verdict       = head.verdict;
	assign word_end      = head.word_end;

endmodule

// File: hdl/dwm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// read during write to the same address returns the old data; no dependencies
module dwm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/dwm_clear.sv
// post-reset clearing sweep over the table memories, one entry per cycle
// no dependencies; drives the sweep address and the busy flag
module dwm_clear #(
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	output logic                                   busy,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr
);

	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic          busy_q;
	logic [AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

// File: hdl/dwm_outbuf.sv
// two-entry result buffer between the pipeline and the result channel
// depends on dwm_pkg for the result and status types
module dwm_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dwm_pkg::result_t     push_data,
	output dwm_pkg::buf_status_t status,
	output logic                 result_valid,
	input  logic                 result_stall,
	output dwm_pkg::result_t     head
);
	import dwm_pkg::*;

	logic [1:0] cnt_q;
	result_t    head_q;
	result_t    skid_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case (cnt_q)
				2'd0: begin
					if (push) cnt_q <= 2'd1;
				end
				2'd1: begin
					if (push && !pop) cnt_q <= 2'd2;
					else if (!push && pop) cnt_q <= 2'd0;
				end
				2'd2: begin
					if (pop && !push) cnt_q <= 2'd1;
				end
				default: cnt_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) head_q <= push_data;
			end
			2'd1: begin
				if (push && pop) head_q <= push_data;
				else if (push) skid_q <= push_data;
			end
			2'd2: begin
				if (pop) begin
					head_q <= skid_q;
					if (push) skid_q <= push_data;
				end
			end
			default: ;
		endcase
	end

	assign status.empty = (cnt_q == 2'd0);
	assign status.full  = (cnt_q == 2'd2);
	assign result_valid = (cnt_q != 2'd0);
	assign head         = head_q;

endmodule

// File: hdl/dwm_checker.sv
// port-level checks for the dfa word matcher, bound to the top level
// depends on dwm_pkg and on the ports of dfa_word_matcher
module dwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] operation,
	input logic       result_valid,
	input logic       result_stall,
	input logic [5:0] current_state,
	input logic [1:0] verdict,
	input logic       word_end
);
	import dwm_pkg::*;

	logic feed_acc;
	assign feed_acc = item_valid && !item_stall && operation == OP_FEED;

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(current_state) &&
		$stable(verdict) && $stable(word_end))
		else $error("stalled result changed");

	// final verdict exactly on the word's last symbol
	a_verdict_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((verdict != V_RUN) == word_end))
		else $error("verdict does not match word end");

	// no two feeds are accepted back to back
	a_feed_gap: assert property (@(posedge clk) disable iff (!arst_n)
		feed_acc |=> !feed_acc)
		else $error("feed accepted in back-to-back cycles");

	// a result only shows up after a fed symbol
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(feed_acc, 3))
		else $error("result without a feed");

endmodule

bind dfa_word_matcher dwm_checker u_dwm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.operation     (operation),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.current_state (current_state),
	.verdict       (verdict),
	.word_end      (word_end)
);

// File: dv/tb_top.sv
// testbench for the dfa word matcher: random automata loaded into the table, words fed
// through them, every result checked against a local model; depends on dwm_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
	import dwm_pkg::*;

	// the limit has to cover the clearing pass after reset, which takes no transaction
	localparam int         STALL_LIMIT = 60000;
	localparam int         DRAIN_CYCLES = 10;
	localparam int         IDLE_PCT = 11;
	localparam int         ROUND_ITEMS = 290;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		bit       ok;
		bit [5:0] next;
	} arc_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [1:0] operation = '0;
	logic [5:0] state_index = '0;
	logic [7:0] symbol = '0;
	logic [5:0] target_state = '0;
	logic       flag_value = 1'b0;
	logic       last_symbol = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [5:0] current_state;
	logic [1:0] verdict;
	logic       word_end;

	// local copy of the automaton
	arc_t     arcs [0:STATE_COUNT_DEF*256-1];
	bit       accepting [0:STATE_COUNT_DEF-1];
	bit [5:0] walk_state;
	bit       walk_dead;
	result_t  expected_results [$];

	bit idling_on = 1'b1;
	int errors;
	int items_sent;
	int results_seen;
	int stuck_cycles;
	int verdict_seen [0:3];

	dfa_word_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.state_index(state_index),
		.symbol(symbol),
		.target_state(target_state),
		.flag_value(flag_value),
		.last_symbol(last_symbol),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.current_state(current_state),
		.verdict(verdict),
		.word_end(word_end)
	);

	always #5 clk = ~clk;

	// advance the automaton by one transaction, queue the result a feed gives
	function automatic void step_automaton(logic [1:0] op, logic [5:0] st, logic [7:0] sym,
			logic [5:0] tgt, logic flg, logic lst);
		result_t r;
		arc_t    a;
		case (op)
			OP_LOAD: arcs[{st, sym}] = '{ok: flg, next: tgt};
			OP_FLAG: accepting[st] = flg;
			OP_FEED: begin
				if (!walk_dead) begin
					a = arcs[{walk_state, sym}];
					if (a.ok)
						walk_state = a.next;
					else
						walk_dead = 1'b1;
				end
				r.current_state = walk_state;
				r.word_end = lst;
				if (!lst)
					r.verdict = V_RUN;
				else if (walk_dead)
					r.verdict = V_NOTRANS;
				else if (accepting[walk_state])
					r.verdict = V_ACCEPT;
				else
					r.verdict = V_REJECT;
				if (lst) begin
					walk_state = '0;
					walk_dead = 1'b0;
				end
				expected_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic void report_mismatch(string field, int unsigned want_v,
			int unsigned got_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
		errors++;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] op, input logic [5:0] st, input logic [7:0] sym,
			input logic [5:0] tgt, input logic flg, input logic lst);
		if (idling_on && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		state_index <= st;
		symbol <= sym;
		target_state <= tgt;
		flag_value <= flg;
		last_symbol <= lst;
		do @(posedge clk); while (item_stall);
		step_automaton(op, st, sym, tgt, flg, lst);
		items_sent++;
		@(negedge clk);
	endtask

	// state_index, target_state and flag_value mean nothing on a feed, so they get noise
	task automatic feed_symbol(input logic [7:0] sym, input logic lst);
		send_item(OP_FEED, 6'($urandom), sym, 6'($urandom), 1'($urandom), lst);
	endtask

	// random automaton over a few states and symbols, then mostly words through it
	task automatic run_round(input int budget);
		logic [5:0] pool [0:7];
		logic [7:0] alpha [0:3];
		int         start_count;
		int         pick;
		int         len;
		start_count = items_sent;
		pool[0] = '0;
		for (int i = 1; i < 8; i++)
			pool[i] = 6'($urandom_range(0, 63));
		for (int j = 0; j < 4; j++)
			alpha[j] = 8'($urandom_range(0, 255));
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 4; j++)
				send_item(OP_LOAD, pool[i], alpha[j], pool[$urandom_range(0, 7)],
					$urandom_range(99) < 92, 1'($urandom));
		for (int i = 0; i < 8; i++)
			send_item(OP_FLAG, pool[i], 8'($urandom), 6'($urandom), 1'($urandom), 1'($urandom));
		while (items_sent - start_count < budget) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					feed_symbol($urandom_range(99) < 92 ? alpha[$urandom_range(0, 3)]
						: 8'($urandom_range(0, 255)), k == len - 1);
			end else if (pick < 88)
				send_item(OP_LOAD, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom),
					1'($urandom));
			else if (pick < 95)
				send_item(OP_FLAG, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom),
					1'($urandom));
			else
				send_item(OP_UNUSED, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom),
					1'($urandom));
		end
	endtask

	task automatic test_directed();
		// 0 -61-> 1 -ff-> 63 -00-> 0, only 63 accepting
		send_item(OP_LOAD, 6'd0, 8'h61, 6'd1, 1'b1, 1'b0);
		send_item(OP_LOAD, 6'd1, 8'hff, 6'd63, 1'b1, 1'b1);
		send_item(OP_LOAD, 6'd63, 8'h00, 6'd0, 1'b1, 1'b0);
		send_item(OP_FLAG, 6'd63, 8'h00, 6'd0, 1'b1, 1'b0);
		send_item(OP_FLAG, 6'd0, 8'hff, 6'd63, 1'b0, 1'b1);
		// operation 3 gives no result
		send_item(OP_UNUSED, 6'h3f, 8'hff, 6'h3f, 1'b1, 1'b1);
		// accepted word
		feed_symbol(8'h61, 1'b0);
		feed_symbol(8'hff, 1'b1);
		// ends on a non-accepting state
		feed_symbol(8'h61, 1'b1);
		// single-symbol word with no transition from state 0
		feed_symbol(8'h00, 1'b1);
		// word dies in the middle and keeps running until its end
		feed_symbol(8'h61, 1'b0);
		feed_symbol(8'h00, 1'b0);
		feed_symbol(8'hff, 1'b0);
		feed_symbol(8'h61, 1'b1);
		// loops back through state 0
		feed_symbol(8'h61, 1'b0);
		feed_symbol(8'hff, 1'b0);
		feed_symbol(8'h00, 1'b0);
		feed_symbol(8'h61, 1'b0);
		feed_symbol(8'hff, 1'b1);
		// load taking effect in the middle of a word
		feed_symbol(8'h61, 1'b0);
		send_item(OP_LOAD, 6'd1, 8'h10, 6'd5, 1'b1, 1'b0);
		feed_symbol(8'h10, 1'b1);
		// entry overwritten as invalid
		send_item(OP_LOAD, 6'd0, 8'h61, 6'd1, 1'b0, 1'b0);
		feed_symbol(8'h61, 1'b1);
	endtask

	task automatic test_random_words();
		for (int n = 0; n < 3; n++)
			run_round(ROUND_ITEMS);
	endtask

	task automatic test_back_to_back();
		idling_on = 1'b0;
		run_round(ROUND_ITEMS);
		idling_on = 1'b1;
	endtask

	always @(negedge clk)
		result_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			verdict_seen[verdict]++;
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, state %0d verdict %0d end %0b",
					$time, current_state, verdict, word_end);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (current_state !== want.current_state)
					report_mismatch("current_state", want.current_state, current_state);
				if (verdict !== want.verdict)
					report_mismatch("verdict", want.verdict, verdict);
				if (word_end !== want.word_end)
					report_mismatch("word_end", want.word_end, word_end);
			end
		end
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_words();
		test_back_to_back();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d transactions sent, %0d results checked", items_sent, results_seen);
		$display("verdicts: %0d running, %0d accepted, %0d no transition, %0d rejected",
			verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
